@@ sv/euler_321_to_quaternion_macros.svh @@
// Assertion macros used by the quaternion conversion queue
`ifndef EULER_321_TO_QUATERNION_MACROS_SVH
`define EULER_321_TO_QUATERNION_MACROS_SVH
`ifndef SYNTHESIS
// Check an implication that must hold in the same cycle
`define E2Q_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("e2q assertion failed");
// Check an implication whose consequence must hold in the next cycle
`define E2Q_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("e2q assertion failed");
`else
`define E2Q_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define E2Q_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ sv/e2q_pkg.sv @@
// Shared constants, types and elaboration-time table functions
package e2q_pkg;

  localparam int DEF_ANGLE_BITS   = 16;
  localparam int DEF_QUAT_BITS    = 16;
  localparam int DEF_CORDIC_STEPS = 16;

  localparam int Z_W    = 64;  // Q60 half-angle residual
  localparam int XY_W   = 44;  // Q40 CORDIC vector
  localparam int TRIG_W = 32;  // Q30 sine/cosine
  localparam int PROD_W = 64;  // Q60 products

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  typedef struct packed {
    logic signed [Z_W-1:0] roll;
    logic signed [Z_W-1:0] pitch;
    logic signed [Z_W-1:0] yaw;
  } z_trio_t;

  // unsigned 64-bit quotient by shift and subtract
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    int j;
    q = '0;
    rem = '0;
    for (j = 63; j >= 0; j--) begin
      rem = {rem[63:0], num[j]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60 by alternating series, pi/4 taken directly for i = 0
  function automatic logic signed [63:0] atan_q60(input int i);
    logic signed [63:0] acc;
    logic [63:0] t;
    int k;
    int e;
    acc = '0;
    if (i == 0) begin
      acc = $signed(PI_Q60 >> 2);
    end else begin
      for (k = 0; k <= 30; k++) begin
        e = i * (2 * k + 1);
        if (e <= 60) begin
          t = udiv64(64'd1 << (60 - e), 64'(2 * k + 1));
          if (k[0]) acc = acc - $signed(t);
          else acc = acc + $signed(t);
        end
      end
    end
    return acc;
  endfunction

  // CORDIC start value K in Q40
  function automatic logic signed [XY_W-1:0] cordic_k_q40(input int steps);
    logic [63:0] k2;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    int i;
    k2 = 64'd1 << 60;
    k2 = k2 >> 1;
    for (i = 1; i < steps; i++) begin
      k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
    end
    n = k2;
    r = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return XY_W'(r << 10);
  endfunction

endpackage

@@ sv/e2q_front.sv @@
// Front end: takes angle requests and scales them to Q60 half angles
module e2q_front import e2q_pkg::*; #(
  parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ANGLE_BITS-1:0] roll_angle,
  input  logic signed [ANGLE_BITS-1:0] pitch_angle,
  input  logic signed [ANGLE_BITS-1:0] yaw_angle,
  output logic                         fr_valid,
  input  logic                         fr_ready,
  output z_trio_t                      fr_data
);

  localparam logic signed [Z_W-1:0] ZSCALE = $signed(PI_Q60 >> ANGLE_BITS);

  logic    hold;
  z_trio_t data_next;

  assign in_ready = !hold || fr_ready;

  // scale each angle: half angle in Q60 radians
  always_comb begin
    data_next.roll  = Z_W'($signed(roll_angle))  * ZSCALE;
    data_next.pitch = Z_W'($signed(pitch_angle)) * ZSCALE;
    data_next.yaw   = Z_W'($signed(yaw_angle))   * ZSCALE;
  end

  // hold the request until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (in_ready) begin
      hold <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      fr_data <= data_next;
    end
  end

  assign fr_valid = hold;

endmodule

@@ sv/e2q_queue.sv @@
// Two-entry queue between the front end and the CORDIC pipeline
`include "euler_321_to_quaternion_macros.svh"
module e2q_queue import e2q_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  z_trio_t push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output z_trio_t pop_data
);

  z_trio_t     mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // write the entry at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  `E2Q_ASSERT_NOW(a_count_max, clk, rst, 1'b1, count <= 2'd2)
  `E2Q_ASSERT_NEXT(a_fill_up, clk, rst, push && !pop, count == $past(count) + 2'd1)
  `E2Q_ASSERT_NEXT(a_drain, clk, rst, pop && !push, count == $past(count) - 2'd1)

endmodule

@@ sv/e2q_back.sv @@
// Back end: CORDIC lanes, triple products, rounding and saturation
module e2q_back import e2q_pkg::*; #(
  parameter int QUAT_BITS    = DEF_QUAT_BITS,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        bk_valid,
  output logic                        bk_ready,
  input  z_trio_t                     bk_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [QUAT_BITS-1:0] quat_w,
  output logic signed [QUAT_BITS-1:0] quat_x,
  output logic signed [QUAT_BITS-1:0] quat_y,
  output logic signed [QUAT_BITS-1:0] quat_z
);

  localparam int NSTG = CORDIC_STEPS + 5;
  localparam int SH   = 61 - QUAT_BITS;
  localparam logic signed [XY_W-1:0] K_Q40 = cordic_k_q40(CORDIC_STEPS);
  localparam logic signed [63:0] RND_OUT = 64'sd1 <<< (SH - 1);
  localparam logic signed [63:0] Q_HI = (64'sd1 <<< (QUAT_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] Q_LO = -(64'sd1 <<< (QUAT_BITS - 1));

  logic                     adv;
  logic [NSTG-1:0]          vld;

  logic signed [XY_W-1:0]   cx [CORDIC_STEPS][3];
  logic signed [XY_W-1:0]   cy [CORDIC_STEPS][3];
  logic signed [Z_W-1:0]    cz [CORDIC_STEPS][3];

  logic signed [TRIG_W-1:0] cs_c [3];
  logic signed [TRIG_W-1:0] cs_s [3];

  logic signed [PROD_W-1:0] p_cc, p_ss, p_sc, p_cs;
  logic signed [TRIG_W-1:0] p1_cy, p1_sy;
  logic signed [PROD_W-1:0] t_ccy, t_ssy, t_scy, t_csy, t_csc, t_scs, t_ccs, t_ssc;
  logic signed [PROD_W-1:0] s_w, s_x, s_y, s_z;
  logic signed [Z_W-1:0]    z0 [3];

  assign adv      = !vld[NSTG-1] || out_ready;
  assign bk_ready = adv;
  assign out_valid = vld[NSTG-1];

  assign z0[0] = bk_data.roll;
  assign z0[1] = bk_data.pitch;
  assign z0[2] = bk_data.yaw;

  // advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], bk_valid};
    end
  end

  // CORDIC rotation stages, three lanes each
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [Z_W-1:0] ATAN_I = atan_q60(i);
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic signed [XY_W-1:0] xi, yi;
      logic signed [Z_W-1:0]  zi;
      if (i == 0) begin : g_first
        assign xi = K_Q40;
        assign yi = '0;
        assign zi = z0[l];
      end else begin : g_next
        assign xi = cx[i-1][l];
        assign yi = cy[i-1][l];
        assign zi = cz[i-1][l];
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          if (!zi[Z_W-1]) begin
            cx[i][l] <= xi - (yi >>> i);
            cy[i][l] <= yi + (xi >>> i);
            cz[i][l] <= zi - ATAN_I;
          end else begin
            cx[i][l] <= xi + (yi >>> i);
            cy[i][l] <= yi - (xi >>> i);
            cz[i][l] <= zi + ATAN_I;
          end
        end
      end
    end
  end

  // round cosine and sine to Q30
  for (genvar l = 0; l < 3; l++) begin : g_rnd
    logic signed [XY_W-1:0] xr, yr;
    assign xr = (cx[CORDIC_STEPS-1][l] + XY_W'(512)) >>> 10;
    assign yr = (cy[CORDIC_STEPS-1][l] + XY_W'(512)) >>> 10;
    always_ff @(posedge clk) begin
      if (adv) begin
        cs_c[l] <= xr[TRIG_W-1:0];
        cs_s[l] <= yr[TRIG_W-1:0];
      end
    end
  end

  // first products: roll by pitch terms
  always_ff @(posedge clk) begin
    if (adv) begin
      p_cc  <= PROD_W'(cs_c[0]) * PROD_W'(cs_c[1]);
      p_ss  <= PROD_W'(cs_s[0]) * PROD_W'(cs_s[1]);
      p_sc  <= PROD_W'(cs_s[0]) * PROD_W'(cs_c[1]);
      p_cs  <= PROD_W'(cs_c[0]) * PROD_W'(cs_s[1]);
      p1_cy <= cs_c[2];
      p1_sy <= cs_s[2];
    end
  end

  // round pair products to Q30 and multiply by the yaw terms
  logic signed [PROD_W-1:0] r_cc, r_ss, r_sc, r_cs;
  assign r_cc = (p_cc + (64'sd1 <<< 29)) >>> 30;
  assign r_ss = (p_ss + (64'sd1 <<< 29)) >>> 30;
  assign r_sc = (p_sc + (64'sd1 <<< 29)) >>> 30;
  assign r_cs = (p_cs + (64'sd1 <<< 29)) >>> 30;

  always_ff @(posedge clk) begin
    if (adv) begin
      t_ccy <= PROD_W'($signed(r_cc[TRIG_W-1:0])) * PROD_W'(p1_cy);
      t_ssy <= PROD_W'($signed(r_ss[TRIG_W-1:0])) * PROD_W'(p1_sy);
      t_scy <= PROD_W'($signed(r_sc[TRIG_W-1:0])) * PROD_W'(p1_cy);
      t_csy <= PROD_W'($signed(r_cs[TRIG_W-1:0])) * PROD_W'(p1_sy);
      t_csc <= PROD_W'($signed(r_cs[TRIG_W-1:0])) * PROD_W'(p1_cy);
      t_scs <= PROD_W'($signed(r_sc[TRIG_W-1:0])) * PROD_W'(p1_sy);
      t_ccs <= PROD_W'($signed(r_cc[TRIG_W-1:0])) * PROD_W'(p1_sy);
      t_ssc <= PROD_W'($signed(r_ss[TRIG_W-1:0])) * PROD_W'(p1_cy);
    end
  end

  // combine triple products per component
  always_ff @(posedge clk) begin
    if (adv) begin
      s_w <= t_ccy + t_ssy;
      s_x <= t_scy - t_csy;
      s_y <= t_csc + t_scs;
      s_z <= t_ccs - t_ssc;
    end
  end

  function automatic logic signed [QUAT_BITS-1:0] to_out(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + RND_OUT) >>> SH;
    if (r > Q_HI) r = Q_HI;
    if (r < Q_LO) r = Q_LO;
    return r[QUAT_BITS-1:0];
  endfunction

  // round, saturate and hold the result
  always_ff @(posedge clk) begin
    if (adv) begin
      quat_w <= to_out(s_w);
      quat_x <= to_out(s_x);
      quat_y <= to_out(s_y);
      quat_z <= to_out(s_z);
    end
  end

endmodule

@@ sv/euler_321_to_quaternion.sv @@
// Each CORDIC iteration and product has its own stage in the back end.
// Throughput: one request per cycle unless out_ready stalls the pipeline.
// A two-entry queue sits between the angle front end and the pipeline.
// Reset (rst, synchronous, active high) clears all valids and queue pointers.
// Top level: 3-2-1 Euler angles to unit quaternion
module euler_321_to_quaternion import e2q_pkg::*; #(
  parameter int ANGLE_BITS   = DEF_ANGLE_BITS,
  parameter int QUAT_BITS    = DEF_QUAT_BITS,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ANGLE_BITS-1:0] roll_angle,
  input  logic signed [ANGLE_BITS-1:0] pitch_angle,
  input  logic signed [ANGLE_BITS-1:0] yaw_angle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [QUAT_BITS-1:0]  quat_w,
  output logic signed [QUAT_BITS-1:0]  quat_x,
  output logic signed [QUAT_BITS-1:0]  quat_y,
  output logic signed [QUAT_BITS-1:0]  quat_z
);

  logic    fr_valid, fr_ready;
  z_trio_t fr_data;
  logic    bk_valid, bk_ready;
  z_trio_t bk_data;

  e2q_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .roll_angle, .pitch_angle, .yaw_angle,
    .fr_valid, .fr_ready, .fr_data
  );

  e2q_queue u_queue (
    .clk, .rst,
    .push_valid(fr_valid), .push_ready(fr_ready), .push_data(fr_data),
    .pop_valid(bk_valid), .pop_ready(bk_ready), .pop_data(bk_data)
  );

  e2q_back #(.QUAT_BITS(QUAT_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst, .bk_valid, .bk_ready, .bk_data,
    .out_valid, .out_ready, .quat_w, .quat_x, .quat_y, .quat_z
  );

endmodule
